/* hw/rtl/ffsa_pkg.sv */
// Shared types and constants for the first-fit segment allocator.
// No dependencies.
package ffsa_pkg;

    localparam int MAX_SEGMENTS = 16;
    localparam int ADDR_BITS    = 20;
    localparam int IDX_W        = $clog2(MAX_SEGMENTS);
    localparam int CNT_W        = $clog2(MAX_SEGMENTS + 1);
    localparam int SIZE_W       = ADDR_BITS + 1;
    localparam int OWNER_W      = 8;
    localparam int KIND_W       = 2;
    localparam int STATUS_W     = 3;

    typedef logic [ADDR_BITS-1:0] addr_t;
    typedef logic [SIZE_W-1:0]    span_t;
    typedef logic [OWNER_W-1:0]   owner_t;
    typedef logic [IDX_W-1:0]     idx_t;
    typedef logic [CNT_W-1:0]     cnt_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_REQUEST = 2'd0,
        KIND_RELEASE = 2'd1,
        KIND_COMPACT = 2'd2,
        KIND_REPORT  = 2'd3
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 3'd0,
        ST_NOSPACE = 3'd1,
        ST_NOOWNER = 3'd2,
        ST_FULL    = 3'd3,
        ST_BADSIZE = 3'd4
    } status_t;

    typedef struct packed {
        addr_t  start_addr;
        addr_t  last_addr;
        owner_t own;
        logic   free;
    } entry_t;

    // broadcast to the cell row every cycle
    typedef enum logic [2:0] {
        CMD_NONE,
        CMD_WRITE,     // cell idx loads wa
        CMD_SPLIT,     // idx loads wa, idx+1 loads wb, above shift up
        CMD_MERGE,     // idx loads wa, above shift down
        CMD_LOADCLR,   // idx loads wa, above cleared
        CMD_CLEAR      // idx and above cleared
    } cmd_op_t;

    typedef struct packed {
        cmd_op_t op;
        idx_t    idx;
        entry_t  wa;
        entry_t  wb;
    } cmd_t;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_REQ,
        S_REL,
        S_MRG_LOAD,
        S_MRG,
        S_CMP,
        S_CMP_END,
        S_RPT,
        S_RESP
    } state_t;

endpackage

/* hw/rtl/first_fit_segment_allocator_top.sv */
// Top level: sequencer plus a row of segment cells.
// Depends on ffsa_pkg, ffsa_cell, ffsa_ctrl.
//
//   channel | direction | word
//   cfg     | in        | cfg_data: memory size, reloads the table
//   in      | in        | kind, owner, alloc_size
//   out     | out       | status, base_address, seg_start, seg_end, seg_owner, seg_free, last
//
// Each operation walks the cell row one slot per cycle through the sequencer read port.
// After reset or a cfg write, the S_INIT state rebuilds the table before the next word is taken.
// A stalled out channel holds the report walk; the next input is taken once the last result is in the output register.
module first_fit_segment_allocator_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [ffsa_pkg::SIZE_W-1:0]   cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [ffsa_pkg::KIND_W-1:0]   kind,
    input  logic [ffsa_pkg::OWNER_W-1:0]  owner,
    input  logic [ffsa_pkg::SIZE_W-1:0]   alloc_size,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [ffsa_pkg::STATUS_W-1:0] status,
    output logic [ffsa_pkg::ADDR_BITS-1:0] base_address,
    output logic [ffsa_pkg::ADDR_BITS-1:0] seg_start,
    output logic [ffsa_pkg::ADDR_BITS-1:0] seg_end,
    output logic [ffsa_pkg::OWNER_W-1:0]  seg_owner,
    output logic                          seg_free,
    output logic                          last
);
    import ffsa_pkg::*;

    entry_t [MAX_SEGMENTS-1:0] ents;
    cmd_t                      cmd;

    ffsa_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .kind         (kind),
        .owner        (owner),
        .alloc_size   (alloc_size),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .base_address (base_address),
        .seg_start    (seg_start),
        .seg_end      (seg_end),
        .seg_owner    (seg_owner),
        .seg_free     (seg_free),
        .last         (last),
        .ents         (ents),
        .cmd          (cmd)
    );

    for (genvar g = 0; g < MAX_SEGMENTS; g++)
    begin : g_cell
        entry_t lo;
        entry_t hi;
        if (g == 0)
        begin : g_lo0
            assign lo = '0;
        end
        else
        begin : g_lo
            assign lo = ents[g-1];
        end
        if (g == MAX_SEGMENTS - 1)
        begin : g_hiN
            assign hi = '0;
        end
        else
        begin : g_hi
            assign hi = ents[g+1];
        end
        ffsa_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .cmd   (cmd),
            .pos   (idx_t'(g)),
            .lo_in (lo),
            .hi_in (hi),
            .q     (ents[g])
        );
    end

endmodule

/* hw/rtl/ffsa_cell.sv */
// One segment table slot; shifts with its neighbors on split and merge.
// Depends on ffsa_pkg.
module ffsa_cell (
    input  logic            clk,
    input  logic            rst_n,
    input  ffsa_pkg::cmd_t  cmd,
    input  ffsa_pkg::idx_t  pos,
    input  ffsa_pkg::entry_t lo_in,
    input  ffsa_pkg::entry_t hi_in,
    output ffsa_pkg::entry_t q
);
    import ffsa_pkg::*;

    entry_t            ent_reg;
    entry_t            ent_next;
    logic [IDX_W:0]    p;
    logic [IDX_W:0]    k;
    logic [IDX_W:0]    k1;

    assign p  = {1'b0, pos};
    assign k  = {1'b0, cmd.idx};
    assign k1 = k + 1'b1;

    always_comb
    begin
        ent_next = ent_reg;
        case (cmd.op)
            CMD_WRITE:
            begin
                if (p == k) ent_next = cmd.wa;
            end
            CMD_SPLIT:
            begin
                if (p == k)       ent_next = cmd.wa;
                else if (p == k1) ent_next = cmd.wb;
                else if (p > k1)  ent_next = lo_in;
            end
            CMD_MERGE:
            begin
                if (p == k)      ent_next = cmd.wa;
                else if (p > k)  ent_next = hi_in;
            end
            CMD_LOADCLR:
            begin
                if (p == k)      ent_next = cmd.wa;
                else if (p > k)  ent_next = '0;
            end
            CMD_CLEAR:
            begin
                if (p >= k) ent_next = '0;
            end
            default: ent_next = ent_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) ent_reg <= '0;
        else        ent_reg <= ent_next;
    end

    assign q = ent_reg;

endmodule

/* hw/rtl/ffsa_ctrl.sv */
// Sequencer: walks the cell row, issues row commands, drives the result register.
// Depends on ffsa_pkg.
module ffsa_ctrl (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  ffsa_pkg::span_t                   cfg_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [ffsa_pkg::KIND_W-1:0]       kind,
    input  ffsa_pkg::owner_t                  owner,
    input  ffsa_pkg::span_t                   alloc_size,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [ffsa_pkg::STATUS_W-1:0]     status,
    output ffsa_pkg::addr_t                   base_address,
    output ffsa_pkg::addr_t                   seg_start,
    output ffsa_pkg::addr_t                   seg_end,
    output ffsa_pkg::owner_t                  seg_owner,
    output logic                              seg_free,
    output logic                              last,
    input  ffsa_pkg::entry_t [ffsa_pkg::MAX_SEGMENTS-1:0] ents,
    output ffsa_pkg::cmd_t                    cmd
);
    import ffsa_pkg::*;

    state_t  state_reg, state_next;
    cnt_t    cnt_reg, cnt_next;
    cnt_t    i_reg, i_next;
    cnt_t    n_reg, n_next;
    span_t   addr_reg, addr_next;
    span_t   msize_reg, msize_next;
    owner_t  owner_reg, owner_next;
    span_t   size_reg, size_next;
    entry_t  prev_reg, prev_next;
    logic    found_reg, found_next;
    status_t st_reg, st_next;
    addr_t   base_reg, base_next;

    logic    out_valid_reg, out_valid_next;
    status_t o_status_reg, o_status_next;
    addr_t   o_base_reg, o_base_next;
    addr_t   o_start_reg, o_start_next;
    addr_t   o_end_reg, o_end_next;
    owner_t  o_owner_reg, o_owner_next;
    logic    o_free_reg, o_free_next;
    logic    o_last_reg, o_last_next;

    entry_t  rd;
    span_t   len;
    span_t   head_end;
    span_t   head_next;
    span_t   cmp_end;
    span_t   msize_m1;
    cnt_t    i_m1;
    span_t   cfg_clamped;
    logic    at_end;
    logic    slot_free;
    logic    fit;
    logic    rpt_last;

    assign rd        = ents[i_reg[IDX_W-1:0]];
    assign len       = {1'b0, rd.last_addr} - {1'b0, rd.start_addr} + 1'b1;
    assign head_next = {1'b0, rd.start_addr} + size_reg;
    assign head_end  = head_next - 1'b1;
    assign cmp_end   = addr_reg + len - 1'b1;
    assign msize_m1  = msize_reg - 1'b1;
    assign i_m1      = i_reg - 1'b1;
    assign at_end    = (i_reg >= cnt_reg);
    assign slot_free = !out_valid_reg || out_ready;
    assign fit       = rd.free && (len >= size_reg);
    assign rpt_last  = ((i_reg + 1'b1) == cnt_reg);

    always_comb
    begin
        if (cfg_data == '0)
            cfg_clamped = span_t'(1);
        else if (cfg_data[SIZE_W-1] && (cfg_data[SIZE_W-2:0] != '0))
            cfg_clamped = span_t'(1) << ADDR_BITS;
        else
            cfg_clamped = cfg_data;
    end

    assign cfg_ready = (state_reg == S_IDLE);
    assign in_ready  = (state_reg == S_IDLE) && !cfg_valid;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_INIT: state_next = S_IDLE;
            S_IDLE:
            begin
                if (cfg_valid)
                    state_next = S_INIT;
                else if (in_valid)
                begin
                    case (kind_t'(kind))
                        KIND_REQUEST: state_next = (alloc_size == '0) ? S_RESP : S_REQ;
                        KIND_RELEASE: state_next = S_REL;
                        KIND_COMPACT: state_next = S_CMP;
                        KIND_REPORT:  state_next = S_RPT;
                        default:      state_next = S_IDLE;
                    endcase
                end
            end
            S_REQ:      if (at_end || fit) state_next = S_RESP;
            S_REL:      if (at_end) state_next = found_reg ? S_MRG_LOAD : S_RESP;
            S_MRG_LOAD: state_next = S_MRG;
            S_MRG:      if (at_end) state_next = S_RESP;
            S_CMP:      if (at_end) state_next = S_CMP_END;
            S_CMP_END:  state_next = S_RESP;
            S_RPT:      if (slot_free && rpt_last) state_next = S_IDLE;
            S_RESP:     if (slot_free) state_next = S_IDLE;
            default:    state_next = S_IDLE;
        endcase
    end

    // datapath and row commands
    always_comb
    begin
        cnt_next   = cnt_reg;
        i_next     = i_reg;
        n_next     = n_reg;
        addr_next  = addr_reg;
        msize_next = msize_reg;
        owner_next = owner_reg;
        size_next  = size_reg;
        prev_next  = prev_reg;
        found_next = found_reg;
        st_next    = st_reg;
        base_next  = base_reg;

        out_valid_next = out_valid_reg && !out_ready;
        o_status_next  = o_status_reg;
        o_base_next    = o_base_reg;
        o_start_next   = o_start_reg;
        o_end_next     = o_end_reg;
        o_owner_next   = o_owner_reg;
        o_free_next    = o_free_reg;
        o_last_next    = o_last_reg;

        cmd     = '0;
        cmd.op  = CMD_NONE;

        case (state_reg)
            S_INIT:
            begin
                cmd.op  = CMD_LOADCLR;
                cmd.idx = '0;
                cmd.wa  = '{start_addr: '0, last_addr: msize_m1[ADDR_BITS-1:0],
                            own: '0, free: 1'b1};
                cnt_next = cnt_t'(1);
            end
            S_IDLE:
            begin
                if (cfg_valid)
                    msize_next = cfg_clamped;
                else if (in_valid)
                begin
                    owner_next = owner;
                    size_next  = alloc_size;
                    i_next     = '0;
                    n_next     = '0;
                    addr_next  = '0;
                    found_next = 1'b0;
                    base_next  = '0;
                    st_next    = ((kind_t'(kind) == KIND_REQUEST) && (alloc_size == '0))
                                 ? ST_BADSIZE : ST_OK;
                end
            end
            S_REQ:
            begin
                if (at_end)
                    st_next = ST_NOSPACE;
                else if (fit)
                begin
                    if (len == size_reg)
                    begin
                        cmd.op  = CMD_WRITE;
                        cmd.idx = i_reg[IDX_W-1:0];
                        cmd.wa  = '{start_addr: rd.start_addr, last_addr: rd.last_addr,
                                    own: owner_reg, free: 1'b0};
                        base_next = rd.start_addr;
                    end
                    else if (cnt_reg == cnt_t'(MAX_SEGMENTS))
                        st_next = ST_FULL;
                    else
                    begin
                        cmd.op  = CMD_SPLIT;
                        cmd.idx = i_reg[IDX_W-1:0];
                        cmd.wa  = '{start_addr: rd.start_addr,
                                    last_addr: head_end[ADDR_BITS-1:0],
                                    own: owner_reg, free: 1'b0};
                        cmd.wb  = '{start_addr: head_next[ADDR_BITS-1:0],
                                    last_addr: rd.last_addr, own: '0, free: 1'b1};
                        cnt_next  = cnt_reg + 1'b1;
                        base_next = rd.start_addr;
                    end
                end
                else
                    i_next = i_reg + 1'b1;
            end
            S_REL:
            begin
                if (at_end)
                begin
                    if (!found_reg) st_next = ST_NOOWNER;
                    i_next = '0;
                end
                else
                begin
                    if (!rd.free && (rd.own == owner_reg))
                    begin
                        cmd.op  = CMD_WRITE;
                        cmd.idx = i_reg[IDX_W-1:0];
                        cmd.wa  = '{start_addr: rd.start_addr, last_addr: rd.last_addr,
                                    own: '0, free: 1'b1};
                        found_next = 1'b1;
                    end
                    i_next = i_reg + 1'b1;
                end
            end
            S_MRG_LOAD:
            begin
                prev_next = rd;
                i_next    = cnt_t'(1);
            end
            S_MRG:
            begin
                if (!at_end)
                begin
                    if (prev_reg.free && rd.free)
                    begin
                        cmd.op  = CMD_MERGE;
                        cmd.idx = i_m1[IDX_W-1:0];
                        cmd.wa  = '{start_addr: prev_reg.start_addr,
                                    last_addr: rd.last_addr, own: '0, free: 1'b1};
                        prev_next.last_addr = rd.last_addr;
                        cnt_next = cnt_reg - 1'b1;
                    end
                    else
                    begin
                        prev_next = rd;
                        i_next    = i_reg + 1'b1;
                    end
                end
            end
            S_CMP:
            begin
                if (!at_end)
                begin
                    if (!rd.free)
                    begin
                        cmd.op  = CMD_WRITE;
                        cmd.idx = n_reg[IDX_W-1:0];
                        cmd.wa  = '{start_addr: addr_reg[ADDR_BITS-1:0],
                                    last_addr: cmp_end[ADDR_BITS-1:0],
                                    own: rd.own, free: 1'b0};
                        addr_next = addr_reg + len;
                        n_next    = n_reg + 1'b1;
                    end
                    i_next = i_reg + 1'b1;
                end
            end
            S_CMP_END:
            begin
                if ((addr_reg < msize_reg) && (n_reg < cnt_t'(MAX_SEGMENTS)))
                begin
                    cmd.op  = CMD_LOADCLR;
                    cmd.idx = n_reg[IDX_W-1:0];
                    cmd.wa  = '{start_addr: addr_reg[ADDR_BITS-1:0],
                                last_addr: msize_m1[ADDR_BITS-1:0], own: '0, free: 1'b1};
                    cnt_next = n_reg + 1'b1;
                end
                else
                begin
                    if (n_reg < cnt_t'(MAX_SEGMENTS))
                    begin
                        cmd.op  = CMD_CLEAR;
                        cmd.idx = n_reg[IDX_W-1:0];
                    end
                    cnt_next = n_reg;
                end
            end
            S_RPT:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    o_status_next  = ST_OK;
                    o_base_next    = '0;
                    o_start_next   = rd.start_addr;
                    o_end_next     = rd.last_addr;
                    o_owner_next   = rd.free ? '0 : rd.own;
                    o_free_next    = rd.free;
                    o_last_next    = rpt_last;
                    i_next         = i_reg + 1'b1;
                end
            end
            S_RESP:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    o_status_next  = st_reg;
                    o_base_next    = base_reg;
                    o_start_next   = '0;
                    o_end_next     = '0;
                    o_owner_next   = '0;
                    o_free_next    = 1'b0;
                    o_last_next    = 1'b1;
                end
            end
            default: cmd.op = CMD_NONE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            cnt_reg       <= cnt_t'(1);
            msize_reg     <= span_t'(1024);
            out_valid_reg <= 1'b0;
            i_reg         <= '0;
            n_reg         <= '0;
            found_reg     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            msize_reg     <= msize_next;
            out_valid_reg <= out_valid_next;
            i_reg         <= i_next;
            n_reg         <= n_next;
            found_reg     <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg     <= addr_next;
        owner_reg    <= owner_next;
        size_reg     <= size_next;
        prev_reg     <= prev_next;
        st_reg       <= st_next;
        base_reg     <= base_next;
        o_status_reg <= o_status_next;
        o_base_reg   <= o_base_next;
        o_start_reg  <= o_start_next;
        o_end_reg    <= o_end_next;
        o_owner_reg  <= o_owner_next;
        o_free_reg   <= o_free_next;
        o_last_reg   <= o_last_next;
    end

    assign out_valid    = out_valid_reg;
    assign status       = o_status_reg;
    assign base_address = o_base_reg;
    assign seg_start    = o_start_reg;
    assign seg_end      = o_end_reg;
    assign seg_owner    = o_owner_reg;
    assign seg_free     = o_free_reg;
    assign last         = o_last_reg;

endmodule
